// File: rtl/core/rgb565_mip_pyramid_generator_assert.svh
`ifndef RGB565_MIP_PYRAMID_GENERATOR_ASSERT_SVH
`define RGB565_MIP_PYRAMID_GENERATOR_ASSERT_SVH

// same-cycle implication
`define RMPG_ASSERT_NOW(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");

// next-cycle implication
`define RMPG_ASSERT_NEXT(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");

`endif

// File: rtl/core/rmpg_pkg.sv
package rmpg_pkg;

   localparam int MIP_LEVELS     = 4;
   localparam int STAGES         = MIP_LEVELS - 1;
   localparam int MAX_WIDTH_LOG2 = 7;
   localparam int CNT_W          = MAX_WIDTH_LOG2;
   localparam int DIM_W          = MAX_WIDTH_LOG2 + 1;
   localparam int STAGE_W        = $clog2(STAGES);
   localparam int ROW_DEPTH      = (2 << MAX_WIDTH_LOG2) - (2 << (MAX_WIDTH_LOG2 - STAGES));
   localparam int ADDR_W         = $clog2(ROW_DEPTH);
   localparam logic [5:0] GREEN_KEY = 6'd63;

   localparam int QDEPTH = 8;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QENT_W = 31;

   localparam logic [1:0] REG_WIDTH_LOG2  = 2'd0;
   localparam logic [1:0] REG_HEIGHT_LOG2 = 2'd1;
   localparam logic [1:0] REG_TRANS_KEY   = 2'd2;
   localparam logic [1:0] REG_REPL_KEY    = 2'd3;

   // dimension of a stage's input image
   function automatic logic [DIM_W-1:0] stage_dim(input logic [2:0] lg, input int s);
      logic [DIM_W-1:0] d;
      d = DIM_W'(1);
      if (int'(lg) >= s)
         d = DIM_W'(1) << (int'(lg) - s);
      return d;
   endfunction

   function automatic logic [ADDR_W-1:0] stage_offset(input int s);
      int off;
      off = 0;
      for (int j = 0; j < s; j++)
         off += (1 << (MAX_WIDTH_LOG2 - j));
      return ADDR_W'(off);
   endfunction

   function automatic logic [15:0] filter_block(input logic [15:0] p0, input logic [15:0] p1,
                                                 input logic [15:0] p2, input logic [15:0] p3,
                                                 input logic [15:0] tkey, input logic [15:0] rkey);
      logic [15:0] px [4];
      logic [6:0]  rs, bs;
      logic [7:0]  gs;
      logic [2:0]  tr;
      logic [15:0] res;
      px[0] = p0; px[1] = p1; px[2] = p2; px[3] = p3;
      rs = '0; bs = '0; gs = '0; tr = '0;
      for (int i = 0; i < 4; i++) begin
         rs = rs + 7'(px[i][15:11]);
         bs = bs + 7'(px[i][4:0]);
         if (px[i][10:5] != GREEN_KEY)
            gs = gs + 8'(px[i][10:5]);
         else
            tr = tr + 3'd1;
      end
      res = {rs[6:2], gs[7:2], bs[6:2]};
      if (res == tkey)
         res = rkey;
      if (tr > 3'd2)
         res = tkey;
      return res;
   endfunction

endpackage

// File: rtl/core/rgb565_mip_pyramid_generator.sv
// channel | direction | content
// req     | in        | tdata[15:0] base_pixel
// rsp     | out       | tdata: mip_level, col_index, row_index, mip_pixel; tlast last_of_item
// csr     | in        | apb registers width_log2, height_log2, transparent_key, replacement_key
//
// one base texel accepted per cycle unless input is stalled; a stage pass issues and its row
// memory read lands in the next cycle, where the level result is filtered and re-issued to the next
// stage, taking the issue slot from new input for that cycle (up to two per texel).
// a result passes the stage registers and then the result queue; a higher level follows the one below.
// reset is synchronous and clears counters, held texels, queue and registers.
// results queue in an eight-entry buffer; input stalls when it holds more than two.
module rgb565_mip_pyramid_generator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // base_pixel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // mip_level[1:0], col_index[7:2], row_index[13:8],
                                    // mip_pixel[29:14], zero[31:30]
   output logic        rsp_tlast,   // last_of_item
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import rmpg_pkg::*;

   logic [2:0]  wlog_ff, hlog_ff;
   logic [15:0] tkey_ff, rkey_ff;

   logic [CNT_W-1:0] col_ff [STAGES];
   logic [CNT_W-1:0] row_ff [STAGES];
   logic [15:0]      left_ff [STAGES];

   logic [15:0] row_mem [ROW_DEPTH];
   logic [15:0] rd_lo_ff, rd_hi_ff;

   logic               b_v_ff;
   logic [STAGE_W-1:0] b_k_ff;
   logic [5:0]         b_col_ff, b_row_ff;
   logic [15:0]        b_left_ff, b_pix_ff;
   logic               b_last_ff;

   logic [QENT_W-1:0] q_ff [QDEPTH];
   logic [QPTR_W-1:0] q_wr_ff, q_rd_ff;
   logic [QPTR_W:0]   q_cnt_ff;

   // stage view
   logic [CNT_W-1:0] cw [STAGES];
   logic [CNT_W-1:0] rw [STAGES];
   logic [CNT_W-1:0] col_in [STAGES];
   logic [CNT_W-1:0] row_in [STAGES];
   logic             mk [STAGES];

   logic               fb_v;
   logic [15:0]        b_res;
   logic               j_v;
   logic [STAGE_W-1:0] j_k;
   logic [15:0]        j_pix;
   logic [CNT_W-1:0]   j_col, j_row;
   logic [15:0]        j_left;
   logic               j_made, j_last;
   logic [ADDR_W-1:0]  j_base;
   logic               q_push, q_pop;
   logic               cfg_wr;

   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_WIDTH_LOG2:  csr_prdata = {29'd0, wlog_ff};
         REG_HEIGHT_LOG2: csr_prdata = {29'd0, hlog_ff};
         REG_TRANS_KEY:   csr_prdata = {16'd0, tkey_ff};
         REG_REPL_KEY:    csr_prdata = {16'd0, rkey_ff};
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wlog_ff <= 3'd7;
         hlog_ff <= 3'd7;
         tkey_ff <= 16'd2016;
         rkey_ff <= 16'd1984;
      end else if (cfg_wr) begin
         unique case (csr_paddr[3:2])
            REG_WIDTH_LOG2:  wlog_ff <= csr_pwdata[2:0];
            REG_HEIGHT_LOG2: hlog_ff <= csr_pwdata[2:0];
            REG_TRANS_KEY:   tkey_ff <= csr_pwdata[15:0];
            REG_REPL_KEY:    rkey_ff <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   // a result of a lower level re-enters the issue slot ahead of new input
   assign b_res      = filter_block(rd_lo_ff, rd_hi_ff, b_left_ff, b_pix_ff, tkey_ff, rkey_ff);
   assign fb_v       = b_v_ff && (int'(b_k_ff) < STAGES - 1);
   assign req_tready = !fb_v && (q_cnt_ff <= (QPTR_W + 1)'(2));
   assign j_v        = fb_v || (req_tvalid && req_tready);
   assign j_k        = fb_v ? b_k_ff + STAGE_W'(1) : '0;
   assign j_pix      = fb_v ? b_res : req_tdata;

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      logic [DIM_W-1:0] w, h, nc, nr;
      always_comb begin
         w  = stage_dim(wlog_ff, s);
         h  = stage_dim(hlog_ff, s);
         cw[s] = (DIM_W'(col_ff[s]) >= w) ? '0 : col_ff[s];
         rw[s] = (DIM_W'(row_ff[s]) >= h) ? '0 : row_ff[s];
         mk[s] = cw[s][0] && rw[s][0];
         nc = DIM_W'(cw[s]) + DIM_W'(1);
         nr = DIM_W'(rw[s]);
         if (nc >= w) begin
            nc = '0;
            nr = nr + DIM_W'(1);
            if (nr >= h)
               nr = '0;
         end
         col_in[s] = nc[CNT_W-1:0];
         row_in[s] = nr[CNT_W-1:0];
      end
   end

   always_comb begin
      j_col  = '0;
      j_row  = '0;
      j_left = '0;
      j_made = 1'b0;
      j_last = 1'b1;
      j_base = '0;
      for (int s = 0; s < STAGES; s++) begin
         if (int'(j_k) == s) begin
            j_col  = cw[s];
            j_row  = rw[s];
            j_left = left_ff[s];
            j_made = mk[s];
            j_base = stage_offset(s) + ADDR_W'(cw[s]);
            if (s < STAGES - 1)
               j_last = !mk[(s + 1) % STAGES];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < STAGES; s++) begin
            col_ff[s]  <= '0;
            row_ff[s]  <= '0;
            left_ff[s] <= '0;
         end
      end else if (j_v) begin
         for (int s = 0; s < STAGES; s++) begin
            if (int'(j_k) == s) begin
               col_ff[s] <= col_in[s];
               row_ff[s] <= row_in[s];
               if (!cw[s][0])
                  left_ff[s] <= j_pix;
            end
         end
      end
   end

   // upper rows: written on even rows, both neighbours read on odd rows
   always_ff @(posedge clock) begin
      if (j_v && !j_row[0])
         row_mem[j_base] <= j_pix;
      rd_lo_ff <= row_mem[j_base - ADDR_W'(1)];
      rd_hi_ff <= row_mem[j_base];
   end

   always_ff @(posedge clock) begin
      if (reset)
         b_v_ff <= 1'b0;
      else
         b_v_ff <= j_v && j_made;
      b_k_ff    <= j_k;
      b_col_ff  <= j_col[CNT_W-1:1];
      b_row_ff  <= j_row[CNT_W-1:1];
      b_left_ff <= j_left;
      b_pix_ff  <= j_pix;
      b_last_ff <= j_last;
   end

   assign q_push = b_v_ff;
   assign q_pop  = rsp_tvalid && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         q_wr_ff  <= '0;
         q_rd_ff  <= '0;
         q_cnt_ff <= '0;
      end else begin
         if (q_push)
            q_wr_ff <= q_wr_ff + QPTR_W'(1);
         if (q_pop)
            q_rd_ff <= q_rd_ff + QPTR_W'(1);
         q_cnt_ff <= q_cnt_ff + (QPTR_W + 1)'(q_push) - (QPTR_W + 1)'(q_pop);
      end
      if (q_push)
         q_ff[q_wr_ff] <= {b_last_ff, 2'(int'(b_k_ff) + 1), b_col_ff, b_row_ff, b_res};
   end

   assign rsp_tvalid = (q_cnt_ff != '0);
   assign rsp_tlast  = q_ff[q_rd_ff][30];
   assign rsp_tdata  = {2'b00, q_ff[q_rd_ff][15:0], q_ff[q_rd_ff][21:16],
                        q_ff[q_rd_ff][27:22], q_ff[q_rd_ff][29:28]};

endmodule

// File: rtl/core/rmpg_checker.sv
`include "rgb565_mip_pyramid_generator_assert.svh"

module rmpg_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic        csr_pready
);
   `RMPG_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `RMPG_ASSERT_NOW(a_level_nonzero, clock, reset, rsp_tvalid, rsp_tdata[1:0] != 2'd0)
   `RMPG_ASSERT_NOW(a_pad_zero, clock, reset, rsp_tvalid, rsp_tdata[31:30] == 2'd0)
   `RMPG_ASSERT_NOW(a_top_level_last, clock, reset,
      rsp_tvalid && rsp_tdata[1:0] == 2'd3, rsp_tlast)
   `RMPG_ASSERT_NOW(a_pready, clock, reset, req_tvalid || !req_tvalid || req_tready, csr_pready)
endmodule

bind rgb565_mip_pyramid_generator rmpg_checker u_rmpg_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
   .rsp_tlast(rsp_tlast), .csr_pready(csr_pready)
);
